@@ sv/fenw_pkg.sv @@
package fenw_pkg;

	// Defaults for the top-level parameters
	localparam int MAX_SIDE_DEF  = 32;
	localparam int SUM_WIDTH_DEF = 48;

	// Fixed field widths
	localparam int COORD_W    = 5;
	localparam int DELTA_W    = 16;
	localparam int BOX_SUM_W  = 48;
	localparam int SIDE_LEN_W = 6;

	localparam logic [SIDE_LEN_W-1:0] SIDE_LEN_RST = 6'd32;

	// APB register map: word index is paddr[APB_ADDR_W-1]
	localparam int   APB_DATA_W   = 32;
	localparam int   APB_ADDR_W   = 3;
	localparam logic REG_SIDE_LEN = 1'b0;

	localparam logic MODE_UPDATE = 1'b0;
	localparam logic MODE_QUERY  = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_START,
		ST_CORNER,
		ST_WALK,
		ST_DRAIN,
		ST_DONE
	} fenw_state_t;

	typedef struct packed {
		logic clear_start;
		logic clear_en;
		logic item_load;
		logic corner_load;
		logic corner_next;
		logic walk_step;
		logic result_load;
	} fenw_cmd_t;

	typedef struct packed {
		logic clear_last;
		logic item_err;
		logic corner_skip;
		logic corner_last;
		logic walk_last;
	} fenw_stat_t;

endpackage

@@ sv/fenw_item_if.sv @@
interface fenw_item_if;
	logic                                valid;
	logic                                ready;
	logic                                mode;
	logic [fenw_pkg::COORD_W-1:0]        x_lo;
	logic [fenw_pkg::COORD_W-1:0]        y_lo;
	logic [fenw_pkg::COORD_W-1:0]        z_lo;
	logic [fenw_pkg::COORD_W-1:0]        x_hi;
	logic [fenw_pkg::COORD_W-1:0]        y_hi;
	logic [fenw_pkg::COORD_W-1:0]        z_hi;
	logic signed [fenw_pkg::DELTA_W-1:0] delta;

	modport source (
		output valid, mode, x_lo, y_lo, z_lo, x_hi, y_hi, z_hi, delta,
		input  ready
	);
	modport sink (
		input  valid, mode, x_lo, y_lo, z_lo, x_hi, y_hi, z_hi, delta,
		output ready
	);
endinterface

@@ sv/fenw_result_if.sv @@
interface fenw_result_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [fenw_pkg::BOX_SUM_W-1:0] box_sum;
	logic                                  error;

	modport source (
		output valid, box_sum, error,
		input  ready
	);
	modport sink (
		input  valid, box_sum, error,
		output ready
	);
endinterface

@@ sv/fenw_regs.sv @@
module fenw_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [fenw_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [fenw_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [fenw_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                pready,
	output logic [fenw_pkg::SIDE_LEN_W-1:0]     side_len,
	output logic                                cfg_wr
);

	logic                              hit;
	logic [fenw_pkg::SIDE_LEN_W-1:0]   side_len_q;

	assign hit    = (paddr[fenw_pkg::APB_ADDR_W-1] == fenw_pkg::REG_SIDE_LEN);
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_len_q <= fenw_pkg::SIDE_LEN_RST;
		end else if (cfg_wr) begin
			side_len_q <= pwdata[fenw_pkg::SIDE_LEN_W-1:0];
		end
	end

	assign side_len = side_len_q;
	assign prdata   = hit ? {{(fenw_pkg::APB_DATA_W-fenw_pkg::SIDE_LEN_W){1'b0}}, side_len_q}
	                      : '0;

endmodule

@@ sv/fenw_dp.sv @@
module fenw_dp #(
	parameter int MAX_SIDE  = fenw_pkg::MAX_SIDE_DEF,
	parameter int SUM_WIDTH = fenw_pkg::SUM_WIDTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  fenw_pkg::fenw_cmd_t                   cmd,
	output fenw_pkg::fenw_stat_t                  stat,
	input  logic [fenw_pkg::SIDE_LEN_W-1:0]       side_len,
	input  logic                                  mode,
	input  logic [fenw_pkg::COORD_W-1:0]          x_lo,
	input  logic [fenw_pkg::COORD_W-1:0]          y_lo,
	input  logic [fenw_pkg::COORD_W-1:0]          z_lo,
	input  logic [fenw_pkg::COORD_W-1:0]          x_hi,
	input  logic [fenw_pkg::COORD_W-1:0]          y_hi,
	input  logic [fenw_pkg::COORD_W-1:0]          z_hi,
	input  logic signed [fenw_pkg::DELTA_W-1:0]   delta,
	output logic signed [fenw_pkg::BOX_SUM_W-1:0] box_sum,
	output logic                                  error
);

	localparam int CW     = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
	localparam int WW     = (CW + 1 > fenw_pkg::SIDE_LEN_W) ? CW + 1 : fenw_pkg::SIDE_LEN_W;
	localparam int ADDR_W = 3 * CW;
	localparam int DEPTH  = 1 << ADDR_W;
	localparam logic [WW-1:0] SIDE_MAX = WW'(MAX_SIDE);
	localparam logic [WW-1:0] ONE      = WW'(1);

	// latched item
	logic                                mode_q;
	logic [fenw_pkg::COORD_W-1:0]        xl_q, yl_q, zl_q, xh_q, yh_q, zh_q;
	logic signed [fenw_pkg::DELTA_W-1:0] delta_q;

	logic [WW-1:0] side_w, side;
	logic [WW-1:0] xl_w, yl_w, zl_w, xh_w, yh_w, zh_w;
	logic          query;
	logic          upd_err, qry_err, err;

	// walker
	logic [2:0]    k_q;
	logic [WW-1:0] a_q, b_q, c_q;
	logic [WW-1:0] a_st, b_st, c_st;
	logic [WW-1:0] a_nx, b_nx, c_nx;
	logic          a_more, b_more, c_more;
	logic [ADDR_W-1:0] addr;

	// memory pipeline
	logic                  vld_s1, upd_s1, sign_s1;
	logic [ADDR_W-1:0]     addr_s1;
	logic [SUM_WIDTH-1:0]  rd_data_s1;
	logic [SUM_WIDTH-1:0]  tree_nodes_q [DEPTH];
	logic [ADDR_W-1:0]     clr_q;
	logic                  wr_en;
	logic [ADDR_W-1:0]     wr_addr;
	logic [SUM_WIDTH-1:0]  wr_data;
	logic [SUM_WIDTH-1:0]  delta_ext;

	logic [SUM_WIDTH-1:0]                  acc_q;
	logic signed [fenw_pkg::BOX_SUM_W-1:0] sum_ext;
	logic signed [fenw_pkg::BOX_SUM_W-1:0] box_sum_q;
	logic                                  error_q;

	function automatic logic [WW-1:0] axis_next(input logic [WW-1:0] v, input logic qry);
		axis_next = qry ? ((v & (v + ONE)) - ONE) : (v | (v + ONE));
	endfunction

	always_ff @(posedge clk) begin
		if (cmd.item_load) begin
			mode_q  <= mode;
			xl_q    <= x_lo;
			yl_q    <= y_lo;
			zl_q    <= z_lo;
			xh_q    <= x_hi;
			yh_q    <= y_hi;
			zh_q    <= z_hi;
			delta_q <= delta;
		end
	end

	assign side_w = WW'(side_len);
	assign side   = (side_w > SIDE_MAX) ? SIDE_MAX : side_w;
	assign xl_w   = WW'(xl_q);
	assign yl_w   = WW'(yl_q);
	assign zl_w   = WW'(zl_q);
	assign xh_w   = WW'(xh_q);
	assign yh_w   = WW'(yh_q);
	assign zh_w   = WW'(zh_q);
	assign query  = (mode_q == fenw_pkg::MODE_QUERY);

	assign upd_err = (xl_w >= side) || (yl_w >= side) || (zl_w >= side);
	assign qry_err = upd_err || (xh_w >= side) || (yh_w >= side) || (zh_w >= side) ||
	                 (xl_q > xh_q) || (yl_q > yh_q) || (zl_q > zh_q);
	assign err     = query ? qry_err : upd_err;

	// corner k: bit set means that axis uses lo-1 instead of hi
	assign a_st = !query ? xl_w : (k_q[0] ? xl_w - ONE : xh_w);
	assign b_st = !query ? yl_w : (k_q[1] ? yl_w - ONE : yh_w);
	assign c_st = !query ? zl_w : (k_q[2] ? zl_w - ONE : zh_w);

	assign a_nx = axis_next(a_q, query);
	assign b_nx = axis_next(b_q, query);
	assign c_nx = axis_next(c_q, query);
	assign a_more = query ? ((a_q & (a_q + ONE)) != '0) : (a_nx < side);
	assign b_more = query ? ((b_q & (b_q + ONE)) != '0) : (b_nx < side);
	assign c_more = query ? ((c_q & (c_q + ONE)) != '0) : (c_nx < side);

	assign addr = {c_q[CW-1:0], b_q[CW-1:0], a_q[CW-1:0]};

	always_comb begin
		stat             = '0;
		stat.clear_last  = &clr_q;
		stat.item_err    = err;
		stat.corner_skip = query && ((k_q[0] && (xl_q == '0)) ||
		                             (k_q[1] && (yl_q == '0)) ||
		                             (k_q[2] && (zl_q == '0)));
		stat.corner_last = !query || (&k_q);
		stat.walk_last   = !a_more && !b_more && !c_more;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= '0;
		end else if (cmd.item_load) begin
			k_q <= '0;
		end else if (cmd.corner_next) begin
			k_q <= k_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.corner_load) begin
			a_q <= a_st;
			b_q <= b_st;
			c_q <= c_st;
		end else if (cmd.walk_step) begin
			if (c_more) begin
				c_q <= c_nx;
			end else begin
				c_q <= c_st;
				if (b_more) begin
					b_q <= b_nx;
				end else begin
					b_q <= b_st;
					a_q <= a_nx;
				end
			end
		end
	end

	// read issued from walker, modify-write or accumulate in the following cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			upd_s1  <= 1'b0;
			sign_s1 <= 1'b0;
		end else begin
			vld_s1  <= cmd.walk_step;
			upd_s1  <= !query;
			sign_s1 <= ^k_q;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clear_start) begin
			clr_q <= '0;
		end else if (cmd.clear_en) begin
			clr_q <= clr_q + ADDR_W'(1);
		end
	end

	assign delta_ext = {{(SUM_WIDTH-fenw_pkg::DELTA_W){delta_q[fenw_pkg::DELTA_W-1]}}, delta_q};
	assign wr_en     = cmd.clear_en || (vld_s1 && upd_s1);
	assign wr_addr   = cmd.clear_en ? clr_q : addr_s1;
	assign wr_data   = cmd.clear_en ? '0 : rd_data_s1 + delta_ext;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			tree_nodes_q[wr_addr] <= wr_data;
		end
		rd_data_s1 <= tree_nodes_q[addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.item_load) begin
			acc_q <= '0;
		end else if (vld_s1 && !upd_s1) begin
			acc_q <= sign_s1 ? acc_q - rd_data_s1 : acc_q + rd_data_s1;
		end
	end

	generate
		if (SUM_WIDTH >= fenw_pkg::BOX_SUM_W) begin : g_trunc
			assign sum_ext = acc_q[fenw_pkg::BOX_SUM_W-1:0];
		end else begin : g_sext
			assign sum_ext = {{(fenw_pkg::BOX_SUM_W-SUM_WIDTH){acc_q[SUM_WIDTH-1]}}, acc_q};
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (cmd.result_load) begin
			error_q   <= err;
			box_sum_q <= (err || !query) ? '0 : sum_ext;
		end
	end

	assign box_sum = box_sum_q;
	assign error   = error_q;

	a_walk_in_cube: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.walk_step |-> ((a_q < side) && (b_q < side) && (c_q < side)))
		else $error("walker left the active cube");

	a_no_clear_collision: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && upd_s1) |-> !cmd.clear_en)
		else $error("node write-back collides with clearing pass");

	a_no_skipped_walk: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.corner_load |-> !stat.corner_skip)
		else $error("walk started on a corner with a negative coordinate");

endmodule

@@ sv/fenw_ctrl.sv @@
module fenw_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr,
	input  logic                 item_valid,
	output logic                 item_ready,
	output logic                 result_valid,
	input  logic                 result_ready,
	input  fenw_pkg::fenw_stat_t stat,
	output fenw_pkg::fenw_cmd_t  cmd
);

	fenw_pkg::fenw_state_t state_q, state_nx;
	logic                  out_valid_q;
	logic                  out_free;
	logic                  accept;

	assign out_free = !out_valid_q || result_ready;
	assign accept   = item_valid && item_ready;

	always_comb begin
		state_nx = state_q;
		case (state_q)
			fenw_pkg::ST_CLEAR: begin
				if (stat.clear_last) state_nx = fenw_pkg::ST_IDLE;
			end
			fenw_pkg::ST_IDLE: begin
				if (item_valid) state_nx = fenw_pkg::ST_START;
			end
			fenw_pkg::ST_START: begin
				state_nx = stat.item_err ? fenw_pkg::ST_DONE : fenw_pkg::ST_CORNER;
			end
			fenw_pkg::ST_CORNER: begin
				if (!stat.corner_skip) begin
					state_nx = fenw_pkg::ST_WALK;
				end else if (stat.corner_last) begin
					state_nx = fenw_pkg::ST_DRAIN;
				end
			end
			fenw_pkg::ST_WALK: begin
				if (stat.walk_last) begin
					state_nx = stat.corner_last ? fenw_pkg::ST_DRAIN : fenw_pkg::ST_CORNER;
				end
			end
			fenw_pkg::ST_DRAIN: begin
				state_nx = fenw_pkg::ST_DONE;
			end
			fenw_pkg::ST_DONE: begin
				if (out_free) state_nx = fenw_pkg::ST_IDLE;
			end
			default: begin
				state_nx = fenw_pkg::ST_CLEAR;
			end
		endcase
		if (cfg_wr) state_nx = fenw_pkg::ST_CLEAR;
	end

	always_comb begin
		cmd             = '0;
		item_ready      = 1'b0;
		cmd.clear_start = cfg_wr;
		case (state_q)
			fenw_pkg::ST_CLEAR: begin
				cmd.clear_en = 1'b1;
			end
			fenw_pkg::ST_IDLE: begin
				item_ready    = 1'b1;
				cmd.item_load = item_valid;
			end
			fenw_pkg::ST_CORNER: begin
				cmd.corner_load = !stat.corner_skip;
				cmd.corner_next = stat.corner_skip && !stat.corner_last;
			end
			fenw_pkg::ST_WALK: begin
				cmd.walk_step   = 1'b1;
				cmd.corner_next = stat.walk_last && !stat.corner_last;
			end
			fenw_pkg::ST_DONE: begin
				cmd.result_load = out_free;
			end
			default: begin
				cmd.clear_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fenw_pkg::ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.result_load) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = out_valid_q;

	a_load_into_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.result_load |-> out_free)
		else $error("result loaded over an untaken result");

	a_valid_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == fenw_pkg::ST_DONE))
		else $error("result presented outside the done state");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !cfg_wr) |=> (state_q == fenw_pkg::ST_START))
		else $error("accepted item did not start");

endmodule

@@ sv/fenwick_3d_box_sum.sv @@
// Three-dimensional Fenwick tree over a cube of side_len cells per axis (capped at
// MAX_SIDE), one SUM_WIDTH-bit node per cell in a single-port-read, single-port-write
// memory. mode 0 adds delta to cell (x_lo,y_lo,z_lo); mode 1 returns the inclusive
// box sum from eight corner prefixes by inclusion-exclusion. Every item gives exactly
// one result; a bad coordinate or an inverted box sets error, returns zero and leaves
// the tree untouched. Nodes are visited one per clock through the memory port, so an
// update visits nx*ny*nz nodes, n being the tree steps per axis (at most 6 at side
// 32, 216 nodes), and a query visits the sum of the walked prefix sizes, one prefix
// per corner. Results sit in an output register, so a finished result may wait while
// the next item is taken. After reset and after every side_len write the block runs
// a clearing pass over all 2^(3*ceil(log2(MAX_SIDE))) nodes (32768 at the default)
// during which no item is taken; register writes are only legal while the block is
// idle.
module fenwick_3d_box_sum #(
	parameter int MAX_SIDE  = fenw_pkg::MAX_SIDE_DEF,
	parameter int SUM_WIDTH = fenw_pkg::SUM_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	fenw_item_if.sink                       item,
	fenw_result_if.source                   result,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [fenw_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [fenw_pkg::APB_DATA_W-1:0] pwdata,
	output logic [fenw_pkg::APB_DATA_W-1:0] prdata,
	output logic                            pready
);

	logic [fenw_pkg::SIDE_LEN_W-1:0] side_len;
	logic                            cfg_wr;
	fenw_pkg::fenw_cmd_t             cmd;
	fenw_pkg::fenw_stat_t            stat;

	// side_len register and APB decode
	fenw_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.side_len (side_len),
		.cfg_wr   (cfg_wr)
	);

	// sequencer: clear pass, corner loop, tree walk, result transfer
	fenw_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr       (cfg_wr),
		.item_valid   (item.valid),
		.item_ready   (item.ready),
		.result_valid (result.valid),
		.result_ready (result.ready),
		.stat         (stat),
		.cmd          (cmd)
	);

	// node memory, walker counters, accumulator, output register
	fenw_dp #(
		.MAX_SIDE  (MAX_SIDE),
		.SUM_WIDTH (SUM_WIDTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.side_len (side_len),
		.mode     (item.mode),
		.x_lo     (item.x_lo),
		.y_lo     (item.y_lo),
		.z_lo     (item.z_lo),
		.x_hi     (item.x_hi),
		.y_hi     (item.y_hi),
		.z_hi     (item.z_hi),
		.delta    (item.delta),
		.box_sum  (result.box_sum),
		.error    (result.error)
	);

endmodule
